>>> rtl/letter_trie_dictionary_macros.svh
// Assertion helpers for the checker module.
`ifndef LETTER_TRIE_DICTIONARY_MACROS_SVH
`define LETTER_TRIE_DICTIONARY_MACROS_SVH

// Checked only while out of reset.
`define LTD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define LTD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/ltd_pkg.sv
`timescale 1ns / 1ps

package ltd_pkg;

    localparam int NODE_COUNT    = 1024;
    localparam int ALPHABET_SIZE = 26;

    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int CNT_W      = $clog2(NODE_COUNT + 1);
    localparam int LETTER_W   = $clog2(ALPHABET_SIZE);
    localparam int SLOT_COUNT = NODE_COUNT * ALPHABET_SIZE;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);

    localparam int OP_W     = 2;
    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 3;
    localparam int NODE_INDEX_W = 10;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_EXACT  = 2'd1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_POOL_FULL = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;

    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;

    typedef enum logic [1:0] {
        FAIL_NONE    = 2'd0,
        FAIL_INVALID = 2'd1,
        FAIL_POOL    = 2'd2,
        FAIL_MISS    = 2'd3
    } t_fail;

    typedef struct packed {
        logic                ok;
        logic [LETTER_W-1:0] idx;
    } t_letter;

    typedef struct packed {
        logic            first;
        logic            last;
        logic [OP_W-1:0] op;
        t_letter         letter;
    } t_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [NODE_INDEX_W-1:0] node;
    } t_result;

    // Case-folds a raw byte and maps it to a letter index.
    function automatic t_letter fold_letter(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] u;
        logic [CHAR_W-1:0] d;
        t_letter           r;
        u = (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ? c - (CHAR_LOWER_A - CHAR_UPPER_A) : c;
        d = u - CHAR_UPPER_A;
        r.ok  = (u >= CHAR_UPPER_A) && (d < CHAR_W'(ALPHABET_SIZE));
        r.idx = d[LETTER_W-1:0];
        return r;
    endfunction

endpackage

>>> rtl/ltd_front.sv
`timescale 1ns / 1ps

module ltd_front import ltd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic              i_last_char,
    input  logic              i_busy,
    input  logic              i_q_full,
    output logic              o_full,
    output logic              o_q_push,
    output t_cmd              o_q_cmd
);

    logic            r_in_word;
    logic [OP_W-1:0] r_op;
    logic            n_in_word;
    logic [OP_W-1:0] n_op;

    assign o_full   = i_q_full | i_busy;
    assign o_q_push = i_push & ~o_full;

    // opcode is taken from the first request of a word only
    assign o_q_cmd.first  = ~r_in_word;
    assign o_q_cmd.last   = i_last_char;
    assign o_q_cmd.op     = r_in_word ? r_op : i_opcode;
    assign o_q_cmd.letter = fold_letter(i_char_code);

    always_comb begin
        n_in_word = r_in_word;
        n_op      = r_op;
        if (o_q_push) begin
            n_in_word = ~i_last_char;
            n_op      = o_q_cmd.op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_word <= 1'b0;
            r_op      <= OP_INSERT;
        end else begin
            r_in_word <= n_in_word;
            r_op      <= n_op;
        end
    end

endmodule

>>> rtl/ltd_queue.sv
`timescale 1ns / 1ps

module ltd_queue import ltd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              wr_en;
    logic              rd_en;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign wr_en   = i_push & ~o_full;
    assign rd_en   = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/ltd_back.sv
`timescale 1ns / 1ps

module ltd_back import ltd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_empty,
    input  t_cmd    i_q_cmd,
    output logic    o_q_pop,
    output logic    o_busy,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_LOOK  = 5'b00100,
        S_END   = 5'b01000,
        S_RES   = 5'b10000
    } t_state;

    logic [NODE_W-1:0] child_mem [SLOT_COUNT];
    logic              mark_mem  [NODE_COUNT];

    t_state            r_state, n_state;
    logic [SLOT_W-1:0] r_clr, n_clr;
    logic [NODE_W-1:0] r_cur, n_cur;
    t_fail             r_fail, n_fail;
    logic [OP_W-1:0]   r_op, n_op;
    logic              r_last, n_last;
    logic [SLOT_W-1:0] r_addr, n_addr;
    logic [CNT_W-1:0]  r_next_free, n_next_free;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;
    logic [NODE_W-1:0] r_child_q;
    logic              r_mark_q;

    logic              child_rd;
    logic              child_we;
    logic [SLOT_W-1:0] child_waddr;
    logic [NODE_W-1:0] child_wdata;
    logic              mark_rd;
    logic              mark_we;
    logic [NODE_W-1:0] mark_waddr;
    logic              mark_wdata;
    logic [NODE_W-1:0] eff_cur;
    t_fail             eff_fail;
    logic              is_insert;

    assign o_busy   = (r_state == S_CLEAR);
    assign o_empty  = ~r_out_valid;
    assign o_result = r_out;
    assign o_q_pop  = (r_state == S_IDLE) && !i_q_empty;

    // a new word starts at the root with no failure
    assign eff_cur   = i_q_cmd.first ? '0 : r_cur;
    assign eff_fail  = i_q_cmd.first ? FAIL_NONE : r_fail;
    assign is_insert = (r_op == OP_INSERT);

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_cur       = r_cur;
        n_fail      = r_fail;
        n_op        = r_op;
        n_last      = r_last;
        n_addr      = r_addr;
        n_next_free = r_next_free;
        n_out_valid = r_out_valid & ~i_pop;
        n_out       = r_out;
        child_rd    = 1'b0;
        child_we    = 1'b0;
        child_waddr = r_addr;
        child_wdata = r_next_free[NODE_W-1:0];
        mark_rd     = 1'b0;
        mark_we     = 1'b0;
        mark_waddr  = r_cur;
        mark_wdata  = 1'b1;

        case (r_state)
            S_CLEAR: begin
                child_we    = 1'b1;
                child_waddr = r_clr;
                child_wdata = '0;
                mark_we     = (r_clr < SLOT_W'(NODE_COUNT));
                mark_waddr  = r_clr[NODE_W-1:0];
                mark_wdata  = 1'b0;
                n_clr       = r_clr + 1'b1;
                if (r_clr == SLOT_W'(SLOT_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_op   = i_q_cmd.op;
                    n_last = i_q_cmd.last;
                    n_cur  = eff_cur;
                    n_fail = eff_fail;
                    n_addr = SLOT_W'(eff_cur) * SLOT_W'(ALPHABET_SIZE)
                           + SLOT_W'(i_q_cmd.letter.idx);
                    if (eff_fail != FAIL_NONE) begin
                        n_state = i_q_cmd.last ? S_END : S_IDLE;
                    end else if (!i_q_cmd.letter.ok) begin
                        n_fail  = (i_q_cmd.op == OP_INSERT) ? FAIL_INVALID : FAIL_MISS;
                        n_state = i_q_cmd.last ? S_END : S_IDLE;
                    end else begin
                        child_rd = 1'b1;
                        n_state  = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                if (r_child_q == '0) begin
                    if (!is_insert) begin
                        n_fail = FAIL_MISS;
                    end else if (r_next_free < CNT_W'(NODE_COUNT)) begin
                        child_we    = 1'b1;
                        n_cur       = r_next_free[NODE_W-1:0];
                        n_next_free = r_next_free + 1'b1;
                    end else begin
                        n_fail = FAIL_POOL;
                    end
                end else begin
                    n_cur = r_child_q;
                end
                n_state = r_last ? S_END : S_IDLE;
            end
            S_END: begin
                mark_rd = 1'b1;
                n_state = S_RES;
            end
            S_RES: begin
                if (!r_out_valid || i_pop) begin
                    n_out.node = '0;
                    if (is_insert) begin
                        if (r_fail == FAIL_INVALID) begin
                            n_out.status = ST_INVALID;
                        end else if (r_fail == FAIL_POOL) begin
                            n_out.status = ST_POOL_FULL;
                        end else begin
                            n_out.node   = NODE_INDEX_W'(r_cur);
                            n_out.status = r_mark_q ? ST_DUPLICATE : ST_INSERTED;
                            mark_we      = ~r_mark_q;
                        end
                    end else if (r_fail != FAIL_NONE) begin
                        n_out.status = ST_NOT_FOUND;
                    end else if (r_op == OP_EXACT && !r_mark_q) begin
                        n_out.status = ST_NOT_FOUND;
                    end else begin
                        n_out.status = ST_FOUND;
                        n_out.node   = NODE_INDEX_W'(r_cur);
                    end
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (child_we) begin
            child_mem[child_waddr] <= child_wdata;
        end
        if (child_rd) begin
            r_child_q <= child_mem[n_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mark_we) begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        if (mark_rd) begin
            r_mark_q <= mark_mem[r_cur];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_cur       <= '0;
            r_fail      <= FAIL_NONE;
            r_op        <= OP_INSERT;
            r_last      <= 1'b0;
            r_next_free <= CNT_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_cur       <= n_cur;
            r_fail      <= n_fail;
            r_op        <= n_op;
            r_last      <= n_last;
            r_next_free <= n_next_free;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_out  <= n_out;
    end

endmodule

>>> rtl/letter_trie_dictionary.sv
`timescale 1ns / 1ps

// Dictionary of words over A..Z kept as a trie in a pool of NODE_COUNT nodes (node 0 is
// the root). A word is pushed one byte per request, the final byte marked by last_char;
// opcode is taken from the first byte (0 insert, 1 exact search, 2 or 3 prefix lookup).
// Letters match without regard to case. One result per word is popped after its last byte.
// After reset the block sweeps all NODE_COUNT*ALPHABET_SIZE slots of the child table with
// full held high. The lookup engine then takes each byte through an address multiply and
// child-table read, then a child check and optional node allocation; a byte after a
// failure or an invalid letter skips the child check, and the last byte adds the word-end
// mark read and result write. A two-entry queue sits between the front and the lookup
// engine, and a result register lets input continue while a result waits.
module letter_trie_dictionary import ltd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [OP_W-1:0]         i_opcode,
    input  logic [CHAR_W-1:0]       i_char_code,
    input  logic                    i_last_char,
    output logic                    empty,
    input  logic                    pop,
    output logic [STATUS_W-1:0]     o_status,
    output logic [NODE_INDEX_W-1:0] o_node_index
);

    logic    busy;
    logic    q_full;
    logic    q_push;
    t_cmd    q_in;
    logic    q_empty;
    logic    q_pop;
    t_cmd    q_head;
    t_result result;

    ltd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_opcode    (i_opcode),
        .i_char_code (i_char_code),
        .i_last_char (i_last_char),
        .i_busy      (busy),
        .i_q_full    (q_full),
        .o_full      (full),
        .o_q_push    (q_push),
        .o_q_cmd     (q_in)
    );

    ltd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_head)
    );

    ltd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_cmd   (q_head),
        .o_q_pop   (q_pop),
        .o_busy    (busy),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (result)
    );

    assign o_status     = result.status;
    assign o_node_index = result.node;

endmodule

>>> rtl/ltd_checker.sv
`timescale 1ns / 1ps
`include "letter_trie_dictionary_macros.svh"

module ltd_checker import ltd_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    full,
    input logic                    empty,
    input logic                    pop,
    input logic [STATUS_W-1:0]     o_status,
    input logic [NODE_INDEX_W-1:0] o_node_index
);

    // reset drops any result and starts the table sweep
    `LTD_ASSERT_ALWAYS(a_reset_state, i_clk, !i_rst_n |=> (empty && full), "reset state wrong")

    `LTD_ASSERT(a_hold, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_status) && $stable(o_node_index)), "waiting result changed")

    `LTD_ASSERT(a_status_range, i_clk, i_rst_n, !empty |-> (o_status <= ST_NOT_FOUND), "status code out of range")

    `LTD_ASSERT(a_fail_node, i_clk, i_rst_n, (!empty && (o_status == ST_INVALID || o_status == ST_POOL_FULL || o_status == ST_NOT_FOUND)) |-> (o_node_index == '0), "failure with nonzero node")

endmodule

bind letter_trie_dictionary ltd_checker u_ltd_checker (.*);

>>> tb/sv/letter_trie_dictionary_tb.sv
`timescale 1ns / 1ps

module letter_trie_dictionary_tb;
    import ltd_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 6;
    localparam int TIMEOUT_NS   = 2_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int DICT_MAX     = 512;
    localparam int MAX_LEN      = 32;
    localparam int FILL_LEN     = 30;

    localparam logic [OP_W-1:0] OP_PREFIX     = 2'd2;
    localparam logic [OP_W-1:0] OP_PREFIX_ALT = 2'd3;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] ch;
        bit                last;
        bit                typed;
        t_result           want;
    } t_stim_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    push;
    logic                    full;
    logic [OP_W-1:0]         i_opcode;
    logic [CHAR_W-1:0]       i_char_code;
    logic                    i_last_char;
    logic                    empty;
    logic                    pop;
    logic [STATUS_W-1:0]     o_status;
    logic [NODE_INDEX_W-1:0] o_node_index;

    letter_trie_dictionary uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_opcode     (i_opcode),
        .i_char_code  (i_char_code),
        .i_last_char  (i_last_char),
        .empty        (empty),
        .pop          (pop),
        .o_status     (o_status),
        .o_node_index (o_node_index)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // trie shadow
    bit [NODE_W-1:0] trie_child [SLOT_COUNT];
    bit              word_marked [NODE_COUNT];
    int              free_node = 1;
    int              walk_node = 0;
    logic [OP_W-1:0] walk_op = OP_INSERT;
    bit              mid_word = 1'b0;
    t_fail           walk_fail = FAIL_NONE;

    t_result pending_results [$];

    // word building and dictionary of inserted words (letter indexes)
    int                  word_letters [$];
    logic [CHAR_W-1:0]   word_bytes [$];
    logic [LETTER_W-1:0] dict_word [DICT_MAX][MAX_LEN];
    int                  dict_len [DICT_MAX];
    int                  dict_count = 0;

    t_stim_row directed_rows [$];

    int mismatches = 0;
    int items_sent = 0;
    int words_done = 0;
    int hold_cycles = 0;
    int status_seen [8];
    bit out_of_reset = 1'b0;
    bit no_idle = 1'b0;
    bit hold_armed = 1'b0;

    function automatic int letter_index(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] up;
        up = (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ? c - (CHAR_LOWER_A - CHAR_UPPER_A) : c;
        if (up < CHAR_UPPER_A || int'(up - CHAR_UPPER_A) >= ALPHABET_SIZE) begin
            return ALPHABET_SIZE;
        end
        return int'(up - CHAR_UPPER_A);
    endfunction

    task automatic trie_step(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                             input bit last, output bit has_result, output t_result res);
        int idx;
        int slot;
        int kid;
        if (!mid_word) begin
            walk_op   = op;
            walk_node = 0;
            walk_fail = FAIL_NONE;
            mid_word  = 1'b1;
        end
        if (walk_fail == FAIL_NONE) begin
            idx = letter_index(ch);
            if (idx >= ALPHABET_SIZE) begin
                walk_fail = (walk_op == OP_INSERT) ? FAIL_INVALID : FAIL_MISS;
            end else begin
                slot = walk_node * ALPHABET_SIZE + idx;
                kid  = trie_child[slot];
                if (kid == 0 && walk_op == OP_INSERT) begin
                    if (free_node < NODE_COUNT) begin
                        kid = free_node;
                        free_node++;
                        trie_child[slot] = NODE_W'(kid);
                    end else begin
                        walk_fail = FAIL_POOL;
                    end
                end else if (kid == 0) begin
                    walk_fail = FAIL_MISS;
                end
                if (walk_fail == FAIL_NONE) walk_node = kid;
            end
        end
        has_result = last;
        res = '0;
        if (last) begin
            mid_word = 1'b0;
            if (walk_op == OP_INSERT) begin
                case (walk_fail)
                    FAIL_INVALID: res.status = ST_INVALID;
                    FAIL_POOL:    res.status = ST_POOL_FULL;
                    default: begin
                        res.node   = NODE_INDEX_W'(walk_node);
                        res.status = word_marked[walk_node] ? ST_DUPLICATE : ST_INSERTED;
                        word_marked[walk_node] = 1'b1;
                    end
                endcase
            end else if (walk_fail != FAIL_NONE) begin
                res.status = ST_NOT_FOUND;
            end else if (walk_op == OP_EXACT && !word_marked[walk_node]) begin
                res.status = ST_NOT_FOUND;
            end else begin
                res.status = ST_FOUND;
                res.node   = NODE_INDEX_W'(walk_node);
            end
        end
    endtask

    task automatic log_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic t_stim_row dir_row(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                                          input bit last, input bit typed,
                                          input logic [STATUS_W-1:0] st,
                                          input logic [NODE_INDEX_W-1:0] node);
        t_stim_row r;
        r.op          = op;
        r.ch          = ch;
        r.last        = last;
        r.typed       = typed;
        r.want.status = st;
        r.want.node   = node;
        return r;
    endfunction

    // One request: random idle, then hold push until full is seen low at an edge.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                             input bit last, input bit typed, input t_result typed_res);
        bit      made;
        t_result res;
        while (!no_idle && $urandom_range(99) < 10) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push        <= 1'b1;
        i_opcode    <= op;
        i_char_code <= ch;
        i_last_char <= last;
        do @(posedge i_clk); while (full !== 1'b0);
        trie_step(op, ch, last, made, res);
        if (made) begin
            pending_results.push_back(typed ? typed_res : res);
            words_done++;
        end
        items_sent++;
    endtask

    // Opcode only matters on the first byte; later bytes carry random junk there.
    task automatic send_word(input logic [OP_W-1:0] op);
        logic [OP_W-1:0] this_op;
        for (int i = 0; i < word_bytes.size(); i++) begin
            this_op = (i == 0) ? op : OP_W'($urandom_range(3));
            send_item(this_op, word_bytes[i], i == word_bytes.size() - 1, 1'b0, '0);
        end
    endtask

    task automatic fresh_word(input int len, input int span);
        word_letters.delete();
        repeat (len) word_letters.push_back($urandom_range(span - 1));
    endtask

    task automatic recall_word(input bit cut);
        int k;
        int n;
        k = $urandom_range(dict_count - 1);
        n = cut ? $urandom_range(dict_len[k], 1) : dict_len[k];
        word_letters.delete();
        for (int i = 0; i < n; i++) word_letters.push_back(int'(dict_word[k][i]));
    endtask

    task automatic spell_word();
        word_bytes.delete();
        foreach (word_letters[i]) begin
            word_bytes.push_back(($urandom_range(1) ? CHAR_LOWER_A : CHAR_UPPER_A)
                                 + CHAR_W'(word_letters[i]));
        end
    endtask

    function automatic logic [CHAR_W-1:0] bad_byte();
        case ($urandom_range(2))
            0:       return CHAR_W'($urandom_range(8'h40));
            1:       return CHAR_W'($urandom_range(8'h60, 8'h5B));
            default: return CHAR_W'($urandom_range(8'hFF, 8'h7B));
        endcase
    endfunction

    task automatic random_word();
        int              pick;
        logic [OP_W-1:0] op;
        pick = $urandom_range(99);
        if (pick < 30) begin
            op = OP_INSERT;
            if (dict_count > 0 && $urandom_range(3) == 0) begin
                recall_word(1'b0);
            end else begin
                if ($urandom_range(1)) fresh_word($urandom_range(4, 1), 5);
                else fresh_word($urandom_range(10, 1), ALPHABET_SIZE);
                if (dict_count < DICT_MAX) begin
                    foreach (word_letters[i]) begin
                        dict_word[dict_count][i] = LETTER_W'(word_letters[i]);
                    end
                    dict_len[dict_count] = word_letters.size();
                    dict_count++;
                end
            end
        end else if (pick < 70) begin
            if (pick < 50) op = OP_EXACT;
            else op = $urandom_range(1) ? OP_PREFIX : OP_PREFIX_ALT;
            if (dict_count > 0 && $urandom_range(3) != 0) recall_word($urandom_range(1));
            else fresh_word($urandom_range(6, 1), 5);
        end else begin
            op = OP_W'($urandom_range(3));
            fresh_word($urandom_range(6, 1), 5);
        end
        spell_word();
        if (pick >= 70 && pick < 85) begin
            word_bytes[$urandom_range(word_bytes.size() - 1)] = bad_byte();
        end else if (pick >= 85) begin
            word_bytes.delete();
            repeat ($urandom_range(4, 1)) word_bytes.push_back(CHAR_W'($urandom_range(255)));
        end
        send_word(op);
    endtask

    task automatic take_result();
        t_result want;
        if (o_status <= ST_NOT_FOUND) status_seen[o_status]++;
        if (pending_results.size() == 0) begin
            log_mismatch($sformatf("unexpected result status %0d node %0d",
                                   o_status, o_node_index));
        end else begin
            want = pending_results.pop_front();
            if (o_status !== want.status) begin
                log_mismatch($sformatf("status %0d, want %0d", o_status, want.status));
            end
            if (o_node_index !== want.node) begin
                log_mismatch($sformatf("node_index %0d, want %0d", o_node_index, want.node));
            end
        end
    endtask

    // Result side
    initial begin
        while (!out_of_reset) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (pop && empty === 1'b0) take_result();
            if (hold_armed) begin
                // long hold-off so the block backs up and pushes back on requests
                hold_armed = 1'b0;
                pop <= 1'b0;
                for (hold_cycles = 0; hold_cycles < HOLD_CYCLES; hold_cycles++) begin
                    @(posedge i_clk);
                end
            end
            pop <= no_idle || $urandom_range(99) >= 10;
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("[%0t] timeout with %0d results pending", $realtime, pending_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int  stop_at;
        bit  hold_fired;
        hold_fired  = 1'b0;
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        pop         <= 1'b0;
        i_opcode    <= OP_INSERT;
        i_char_code <= '0;
        i_last_char <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        out_of_reset = 1'b1;

        // fresh trie: node numbers are handed out from 1 upward
        directed_rows.push_back(dir_row(OP_EXACT,      "A",   1, 1, ST_NOT_FOUND, 0));
        directed_rows.push_back(dir_row(OP_PREFIX,     "z",   1, 1, ST_NOT_FOUND, 0));
        directed_rows.push_back(dir_row(OP_INSERT,     "A",   1, 1, ST_INSERTED,  1));
        directed_rows.push_back(dir_row(OP_INSERT,     "a",   1, 1, ST_DUPLICATE, 1));
        directed_rows.push_back(dir_row(OP_EXACT,      "a",   1, 1, ST_FOUND,     1));
        directed_rows.push_back(dir_row(OP_PREFIX_ALT, "A",   1, 1, ST_FOUND,     1));
        directed_rows.push_back(dir_row(OP_INSERT,     "Z",   0, 0, ST_INSERTED,  0));
        directed_rows.push_back(dir_row(OP_EXACT,      "z",   1, 0, ST_INSERTED,  0));
        // bad letter mid-insert: node for Q stays allocated
        directed_rows.push_back(dir_row(OP_INSERT,     "Q",   0, 0, ST_INSERTED,  0));
        directed_rows.push_back(dir_row(OP_INSERT,     8'h60, 0, 0, ST_INSERTED,  0));
        directed_rows.push_back(dir_row(OP_INSERT,     "R",   1, 1, ST_INVALID,   0));
        directed_rows.push_back(dir_row(OP_PREFIX,     "q",   1, 0, ST_FOUND,     0));
        directed_rows.push_back(dir_row(OP_EXACT,      "Q",   1, 0, ST_NOT_FOUND, 0));
        directed_rows.push_back(dir_row(OP_INSERT,     8'h00, 1, 1, ST_INVALID,   0));
        directed_rows.push_back(dir_row(OP_INSERT,     8'h5B, 1, 1, ST_INVALID,   0));
        directed_rows.push_back(dir_row(OP_INSERT,     8'h40, 1, 1, ST_INVALID,   0));
        directed_rows.push_back(dir_row(OP_EXACT,      8'hFF, 1, 1, ST_NOT_FOUND, 0));
        directed_rows.push_back(dir_row(OP_PREFIX_ALT, 8'h7B, 1, 1, ST_NOT_FOUND, 0));
        // miss in the middle; the rest of the word is dropped
        directed_rows.push_back(dir_row(OP_PREFIX,     "Z",   0, 0, ST_FOUND,     0));
        directed_rows.push_back(dir_row(OP_PREFIX,     "X",   0, 0, ST_FOUND,     0));
        directed_rows.push_back(dir_row(OP_PREFIX,     "Z",   1, 1, ST_NOT_FOUND, 0));
        directed_rows.push_back(dir_row(OP_INSERT,     "z",   0, 0, ST_INSERTED,  0));
        directed_rows.push_back(dir_row(OP_INSERT,     "a",   1, 0, ST_INSERTED,  0));
        directed_rows.push_back(dir_row(OP_EXACT,      "z",   1, 0, ST_NOT_FOUND, 0));
        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].want);
        end

        while (items_sent < 200) begin
            if (!hold_fired && items_sent >= 60) begin
                hold_fired = 1'b1;
                hold_armed = 1'b1;
            end
            no_idle = items_sent >= 100 && items_sent < 190;
            random_word();
        end
        no_idle = 1'b0;

        // long fresh inserts drain the node pool, then a few more run into it
        while (free_node < NODE_COUNT) begin
            fresh_word(FILL_LEN, ALPHABET_SIZE);
            spell_word();
            send_word(OP_INSERT);
        end
        repeat (3) begin
            fresh_word(FILL_LEN, ALPHABET_SIZE);
            spell_word();
            send_word(OP_INSERT);
        end

        stop_at = items_sent + 80;
        while (items_sent < stop_at) random_word();
        push <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests forming %0d words; node pool used %0d of %0d",
                 items_sent, words_done, free_node, NODE_COUNT);
        $display("Result hold-off %0d cycles; inserted %0d, duplicate %0d, invalid %0d",
                 hold_cycles, status_seen[ST_INSERTED], status_seen[ST_DUPLICATE],
                 status_seen[ST_INVALID]);
        $display("Pool full %0d, found %0d, not found %0d",
                 status_seen[ST_POOL_FULL], status_seen[ST_FOUND], status_seen[ST_NOT_FOUND]);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> letter_trie_dictionary.f
+incdir+rtl
rtl/ltd_pkg.sv
rtl/ltd_front.sv
rtl/ltd_queue.sv
rtl/ltd_back.sv
rtl/letter_trie_dictionary.sv
rtl/ltd_checker.sv
tb/sv/letter_trie_dictionary_tb.sv
